// ===== rtl/core/ccs_pkg.sv =====
`timescale 1ns / 1ps

package ccs_pkg;

  // character codes with special meaning
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // output queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one filtered word as it waits in the output queue
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_t;

  // parser flags carried from one byte to the next
  typedef struct packed {
    logic in_comment;
    logic line_comment;
    logic saw_slash;
    logic saw_star;
    logic in_quote;
  } flags_t;

endpackage

// ===== rtl/core/ccs_raw_if.sv =====
`timescale 1ns / 1ps

interface ccs_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/ccs_clean_if.sv =====
`timescale 1ns / 1ps

interface ccs_clean_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/c_comment_stripper_unit.sv =====
`timescale 1ns / 1ps

// channel  | dir | payload            | meaning
// raw      | in  | in_byte, in_last   | raw text word, last marks end of text
// clean    | out | out_byte, out_last | filtered word, comments blanked to space
//
// One raw word is taken per cycle while raw is ready; the parser flags and
// the held byte update in the same cycle as that word is taken.
// Each word yields 0, 1 or 2 clean words into a 4-entry output queue; raw is
// ready while the queue has room for two words, so a stalled sink fills it.
// The clean words released by a raw word are registered into the queue as that raw word is taken.
// rst (synchronous) empties the queue and clears the flags and held byte.

module c_comment_stripper_unit
  import ccs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ccs_raw_if.sink       raw,
  ccs_clean_if.source   clean
);

  // parser state
  logic [7:0]        held_byte;
  logic              held_valid;
  flags_t            flags;
  flags_t            flags_next;

  // output queue
  word_t             queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic              accept;
  logic              pop;
  logic [7:0]        filt;
  logic              blank_prev;
  logic              nl;
  word_t             push0;
  word_t             push1;
  logic              push0_en;
  logic              push1_en;
  logic [QCNT_W-1:0] push_cnt;

  assign raw.ready   = (count <= QCNT_W'(QDEPTH - 2));
  assign accept      = raw.valid && raw.ready;
  assign clean.valid = (count != '0);
  assign pop         = clean.valid && clean.ready;
  assign clean.out_byte = queue[rd_ptr].data;
  assign clean.out_last = queue[rd_ptr].last;

  // byte classification and flag update
  always_comb begin
    flags_next = flags;
    filt       = raw.in_byte;
    blank_prev = 1'b0;
    nl         = (raw.in_byte == CH_LF) || (raw.in_byte == CH_CR);
    priority if (raw.in_byte == CH_SLASH && !flags.in_quote) begin
      if (!flags.in_comment) begin
        if (flags.saw_slash) begin
          // second slash opens a line comment
          flags_next.saw_slash    = 1'b0;
          flags_next.in_comment   = 1'b1;
          flags_next.line_comment = 1'b1;
          filt       = CH_SPACE;
          blank_prev = 1'b1;
        end else begin
          flags_next.saw_slash = 1'b1;
        end
      end else begin
        filt = CH_SPACE;
        if (!flags.line_comment && flags.saw_star) begin
          flags_next.in_comment = 1'b0;
        end
        flags_next.saw_slash = 1'b0;
      end
      flags_next.saw_star = 1'b0;
    end else if (raw.in_byte == CH_STAR && !flags.in_quote) begin
      if (!flags.in_comment) begin
        if (flags.saw_slash) begin
          // slash star opens a block comment
          flags_next.in_comment   = 1'b1;
          flags_next.line_comment = 1'b0;
          filt       = CH_SPACE;
          blank_prev = 1'b1;
        end else begin
          flags_next.saw_star = 1'b1;
        end
      end else begin
        filt = CH_SPACE;
        flags_next.saw_star = 1'b1;
      end
      flags_next.saw_slash = 1'b0;
    end else if (raw.in_byte == CH_QUOTE) begin
      flags_next.saw_slash = 1'b0;
      flags_next.saw_star  = 1'b0;
      if (!flags.in_comment) begin
        flags_next.in_quote = !flags.in_quote;
      end else begin
        filt = CH_SPACE;
      end
    end else begin
      flags_next.saw_slash = 1'b0;
      flags_next.saw_star  = 1'b0;
      if (nl) begin
        flags_next.in_quote = 1'b0;
      end
      if (flags.in_comment) begin
        if (flags.line_comment && nl) begin
          flags_next.in_comment = 1'b0;
        end else if (!nl) begin
          filt = CH_SPACE;
        end
      end
    end
  end

  // words released by this raw word, packed toward the first slot
  always_comb begin
    push0.data = blank_prev ? CH_SPACE : held_byte;
    push0.last = 1'b0;
    push1.data = filt;
    push1.last = 1'b1;
    push0_en   = 1'b0;
    push1_en   = 1'b0;
    if (accept) begin
      if (held_valid) begin
        push0_en = 1'b1;
        push1_en = raw.in_last;
      end else if (raw.in_last) begin
        push0    = push1;
        push0_en = 1'b1;
      end
    end
    push_cnt = QCNT_W'(push0_en) + QCNT_W'(push1_en);
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte  <= '0;
      held_valid <= 1'b0;
      flags      <= '0;
    end else if (accept) begin
      if (raw.in_last) begin
        held_byte  <= '0;
        held_valid <= 1'b0;
        flags      <= '0;
      end else begin
        held_byte  <= filt;
        held_valid <= 1'b1;
        flags      <= flags_next;
      end
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (push0_en) begin
      queue[wr_ptr] <= push0;
    end
    if (push1_en) begin
      queue[wr_ptr + QPTR_W'(1)] <= push1;
    end
  end

  // output queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + push_cnt - QCNT_W'(pop);
    end
  end

endmodule

// ===== rtl/core/ccs_checker.sv =====
`timescale 1ns / 1ps

module ccs_checker (
  input logic       clk,
  input logic       rst,
  input logic       raw_valid,
  input logic       raw_ready,
  input logic       raw_last,
  input logic       clean_valid,
  input logic       clean_ready,
  input logic [7:0] clean_byte,
  input logic       clean_last
);

  // a stalled clean word stays offered
  a_clean_hold: assert property (@(posedge clk) disable iff (rst)
    clean_valid && !clean_ready |=> clean_valid)
    else $error("clean word dropped while stalled");

  // a stalled clean word keeps its payload
  a_clean_stable: assert property (@(posedge clk) disable iff (rst)
    clean_valid && !clean_ready |=> $stable(clean_byte) && $stable(clean_last))
    else $error("clean payload changed while stalled");

  // reset empties the queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !clean_valid)
    else $error("clean word offered after reset");

  // the end of a text always produces a word
  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    raw_valid && raw_ready && raw_last |=> clean_valid)
    else $error("end of text produced no clean word");

  // back-pressure on raw only comes from words waiting on clean
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !raw_ready |-> clean_valid)
    else $error("raw stalled with empty output queue");

endmodule

bind c_comment_stripper_unit ccs_checker u_ccs_checker (
  .clk         (clk),
  .rst         (rst),
  .raw_valid   (raw.valid),
  .raw_ready   (raw.ready),
  .raw_last    (raw.in_last),
  .clean_valid (clean.valid),
  .clean_ready (clean.ready),
  .clean_byte  (clean.out_byte),
  .clean_last  (clean.out_last)
);
